>>> rtl/rcws_pkg.sv
// shared types and constants for the rule cell weighted bin scorer
// no dependencies; used by every module of the block
package rcws_pkg;

   localparam int MAX_DEPTH_DEF = 3;
   localparam int ACC_WIDTH_DEF = 48;
   localparam int CUT_W         = 3;
   localparam int RESP_W        = 32;
   localparam int SCORE_W       = 49;
   localparam int DEPTH_W       = 2;
   localparam int CELL_IDX_W    = 3;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 56;
   localparam int QUEUE_DEPTH   = 4;

   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 2'd1;

   // one classified sample on its way from front to back
   typedef struct packed {
      logic                treated;
      logic [CUT_W-1:0]    cut_mask;
      logic [RESP_W-1:0]   response;
      logic                last;
      logic [DEPTH_W-1:0]  depth;
   } smp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef enum logic {
      BK_ACCUM,
      BK_EMIT
   } bk_state_type;

endpackage

>>> rtl/rule_cell_weighted_bin_scorer_unit.sv
// top level of the rule cell weighted bin scorer
// depends on rcws_pkg, rcws_front, rcws_queue and rcws_back
//
// usage
// - req channel: one sample per word; tuser is the treated flag, tdata holds
//   cut_bits then the signed q16.16 response, tlast marks the final sample
// - csr port: csr_wr_en writes the 2-bit depth; write only while idle
// - rsp channel: one score per rule cell, 2^depth words per set, tlast on the last
// - a sample is accepted every cycle while the queue has room; the queue of
//   four words lets the front keep taking samples while scores drain
// - each sample costs one bin add in the back end, a read-modify-write of one bin
// - the last sample of a set starts score emission of 2^depth scores, one score
//   per cycle while rsp is not stalled, each from one pair of bins; the first
//   score reaches rsp after the queue, the emit state and the output register
// - reset sets depth to 1, empties the queue and marks all bins zero
// - a stalled rsp keeps its word in the output register; the back end stops,
//   the queue fills, then req_tready falls
module rule_cell_weighted_bin_scorer_unit #(
   parameter int MAX_DEPTH = rcws_pkg::MAX_DEPTH_DEF,
   parameter int ACC_WIDTH = rcws_pkg::ACC_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // config
   input  logic                              csr_wr_en,
   input  logic [rcws_pkg::DEPTH_W-1:0]      csr_wr_data,   // depth
   // samples in
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rcws_pkg::REQ_DATA_W-1:0]   req_tdata,     // cut_bits[2:0], response[34:3]
   input  logic                              req_tuser,     // treated
   input  logic                              req_tlast,     // last_sample
   // scores out
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rcws_pkg::RSP_DATA_W-1:0]   rsp_tdata,     // cell_index[2:0], score[51:3]
   output logic                              rsp_tlast      // last_score
);

   rcws_pkg::q_stat_type q_stat;
   rcws_pkg::smp_type    push_entry;
   rcws_pkg::smp_type    head;
   logic                 push;
   logic                 pop;

   // classification and depth register
   rcws_front #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .q_stat      (q_stat),
      .push        (push),
      .push_entry  (push_entry)
   );

   // decoupling queue
   rcws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   // bins, scoring and output register
   rcws_back #(
      .MAX_DEPTH (MAX_DEPTH),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> rtl/rcws_front.sv
// front end: depth register, sample acceptance and cell classification
// depends on rcws_pkg
module rcws_front #(
   parameter int MAX_DEPTH = rcws_pkg::MAX_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [rcws_pkg::DEPTH_W-1:0]      csr_wr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rcws_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   input  rcws_pkg::q_stat_type              q_stat,
   output logic                              push,
   output rcws_pkg::smp_type                 push_entry
);

   logic [rcws_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   logic [rcws_pkg::DEPTH_W-1:0] eff_depth;
   logic [rcws_pkg::CUT_W:0]     mask_wide;
   logic [rcws_pkg::CUT_W-1:0]   cut_bits;

   assign depth_in = csr_wr_en ? csr_wr_data : depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= rcws_pkg::DEPTH_RESET;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_comb begin
      // depth saturates at the built-in maximum
      if ({1'b0, depth_ff} > 3'(MAX_DEPTH)) begin
         eff_depth = rcws_pkg::DEPTH_W'(MAX_DEPTH);
      end else begin
         eff_depth = depth_ff;
      end
      cut_bits  = req_tdata[rcws_pkg::CUT_W-1:0];
      mask_wide = ((rcws_pkg::CUT_W+1)'(1) << eff_depth) - (rcws_pkg::CUT_W+1)'(1);

      push_entry.treated  = req_tuser;
      push_entry.cut_mask = cut_bits & mask_wide[rcws_pkg::CUT_W-1:0];
      push_entry.response = req_tdata[rcws_pkg::CUT_W +: rcws_pkg::RESP_W];
      push_entry.last     = req_tlast;
      push_entry.depth    = eff_depth;
   end

   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && !q_stat.full;

endmodule

>>> rtl/rcws_queue.sv
// short fifo of classified samples between front and back
// depends on rcws_pkg
module rcws_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rcws_pkg::smp_type    push_entry,
   input  logic                 pop,
   output rcws_pkg::smp_type    head,
   output rcws_pkg::q_stat_type q_stat
);

   localparam int QD    = rcws_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(QD);
   localparam int CNT_W = $clog2(QD + 1);

   rcws_pkg::smp_type  mem_ff [QD];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_W'(QD));
   assign q_stat.empty = (count_ff == '0);

endmodule

>>> rtl/rcws_back.sv
// back end: bin accumulation, score emission and bin clearing
// depends on rcws_pkg
module rcws_back #(
   parameter int MAX_DEPTH = rcws_pkg::MAX_DEPTH_DEF,
   parameter int ACC_WIDTH = rcws_pkg::ACC_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rcws_pkg::q_stat_type              q_stat,
   input  rcws_pkg::smp_type                 head,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rcws_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int NUM_CELLS = 2 ** MAX_DEPTH;
   localparam int CELL_W    = MAX_DEPTH;
   localparam int DIFF_W    = (ACC_WIDTH + 1 > rcws_pkg::SCORE_W) ?
                              ACC_WIDTH + 1 : rcws_pkg::SCORE_W;
   localparam int PAD_W     = rcws_pkg::RSP_DATA_W - rcws_pkg::CELL_IDX_W - rcws_pkg::SCORE_W;

   rcws_pkg::bk_state_type state_ff, state_in;

   logic [ACC_WIDTH-1:0]  tr_sum_ff [NUM_CELLS];
   logic [ACC_WIDTH-1:0]  un_sum_ff [NUM_CELLS];
   logic [NUM_CELLS-1:0]  tr_vld_ff, tr_vld_in;
   logic [NUM_CELLS-1:0]  un_vld_ff, un_vld_in;

   logic [CELL_W-1:0]                 j_ff, j_in;
   logic [rcws_pkg::DEPTH_W-1:0]      d_ff, d_in;
   logic                              out_vld_ff, out_vld_in;
   logic [rcws_pkg::CELL_IDX_W-1:0]   out_idx_ff;
   logic [rcws_pkg::SCORE_W-1:0]      out_score_ff;
   logic                              out_last_ff;

   logic [CELL_W-1:0]     head_cell;
   logic [CELL_W-1:0]     rd_addr;
   logic [ACC_WIDTH-1:0]  tr_rd, un_rd, resp_ext, acc_sum;
   logic [DIFF_W-1:0]     diff;
   logic [CELL_W:0]       cells_w;
   logic [CELL_W-1:0]     last_cell;
   logic                  out_free, emit, emit_last;

   always_comb begin
      head_cell = CELL_W'(head.cut_mask);
      rd_addr   = (state_ff == rcws_pkg::BK_EMIT) ? j_ff : head_cell;
      tr_rd     = tr_vld_ff[rd_addr] ? tr_sum_ff[rd_addr] : '0;
      un_rd     = un_vld_ff[rd_addr] ? un_sum_ff[rd_addr] : '0;
      resp_ext  = {{(ACC_WIDTH - rcws_pkg::RESP_W){head.response[rcws_pkg::RESP_W-1]}},
                   head.response};
      acc_sum   = (head.treated ? tr_rd : un_rd) + resp_ext;
      diff      = DIFF_W'($signed(tr_rd)) - DIFF_W'($signed(un_rd));
      cells_w   = (CELL_W+1)'(1) << d_ff;
      last_cell = CELL_W'(cells_w - (CELL_W+1)'(1));
      out_free  = !out_vld_ff || rsp_tready;
      pop       = (state_ff == rcws_pkg::BK_ACCUM) && !q_stat.empty;
      emit      = (state_ff == rcws_pkg::BK_EMIT) && out_free;
      emit_last = emit && (j_ff == last_cell);
   end

   always_comb begin
      state_in  = state_ff;
      j_in      = j_ff;
      d_in      = d_ff;
      tr_vld_in = tr_vld_ff;
      un_vld_in = un_vld_ff;
      unique case (state_ff)
         rcws_pkg::BK_ACCUM: begin
            if (pop) begin
               if (head.treated) begin
                  tr_vld_in[head_cell] = 1'b1;
               end else begin
                  un_vld_in[head_cell] = 1'b1;
               end
               if (head.last) begin
                  state_in = rcws_pkg::BK_EMIT;
                  j_in     = '0;
                  d_in     = head.depth;
               end
            end
         end
         rcws_pkg::BK_EMIT: begin
            if (emit) begin
               j_in = j_ff + 1'b1;
               if (emit_last) begin
                  // every bin reads as zero again
                  tr_vld_in = '0;
                  un_vld_in = '0;
                  state_in  = rcws_pkg::BK_ACCUM;
               end
            end
         end
         default: begin
            state_in = rcws_pkg::BK_ACCUM;
         end
      endcase
      if (emit) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= rcws_pkg::BK_ACCUM;
         tr_vld_ff  <= '0;
         un_vld_ff  <= '0;
         out_vld_ff <= 1'b0;
         j_ff       <= '0;
         d_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         tr_vld_ff  <= tr_vld_in;
         un_vld_ff  <= un_vld_in;
         out_vld_ff <= out_vld_in;
         j_ff       <= j_in;
         d_ff       <= d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         if (head.treated) begin
            tr_sum_ff[head_cell] <= acc_sum;
         end else begin
            un_sum_ff[head_cell] <= acc_sum;
         end
      end
      if (emit) begin
         out_idx_ff   <= rcws_pkg::CELL_IDX_W'(j_ff);
         out_score_ff <= diff[rcws_pkg::SCORE_W-1:0];
         out_last_ff  <= (j_ff == last_cell);
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_score_ff, out_idx_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

>>> rtl/rcws_checker.sv
// port-level checks for the rule cell weighted bin scorer, bound to the top level
// depends on rcws_pkg and rule_cell_weighted_bin_scorer_unit
module rcws_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rcws_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tlast
);

   logic rsp_take;
   logic [rcws_pkg::CELL_IDX_W-1:0] idx;

   assign rsp_take = rsp_tvalid && rsp_tready;
   assign idx      = rsp_tdata[rcws_pkg::CELL_IDX_W-1:0];

   // stalled score holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled score changed");

   // nothing leaves straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("score valid after reset");

   // final score of a run sits on the top cell of a power-of-two run
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_tlast |-> (idx == 3'd0 || idx == 3'd1 || idx == 3'd3 || idx == 3'd7))
      else $error("run ended on a wrong cell");

   // a run never goes past cell seven without ending
   a_nonlast_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_tlast |-> idx != 3'd7)
      else $error("cell seven not marked last");

endmodule

bind rule_cell_weighted_bin_scorer_unit rcws_checker u_rcws_checker (.*);

>>> test/rule_cell_weighted_bin_scorer_unit_test.sv
// self-checking testbench for rule_cell_weighted_bin_scorer_unit: a short table of
// directed samples, then random sample sets, every score word checked against a local
// bin predictor; depends on rcws_pkg and the rtl of the block
module rule_cell_weighted_bin_scorer_unit_test;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_DEPTH
   } row_kind_type;

   // one line of the directed table: either a depth write or a sample word
   typedef struct {
      row_kind_type                    kind;
      logic [rcws_pkg::DEPTH_W-1:0]    depth;
      logic                            treated;
      logic [rcws_pkg::CUT_W-1:0]      cut;
      logic [rcws_pkg::RESP_W-1:0]     resp;
      logic                            last;
      logic                            typed;   // cell 0 score typed in, every other cell zero
      logic [rcws_pkg::SCORE_W-1:0]    cell0_score;
   } stim_row_type;

   typedef struct {
      logic [rcws_pkg::CELL_IDX_W-1:0] cell_idx;
      logic [rcws_pkg::SCORE_W-1:0]    score;
      logic                            last;
   } score_word_type;

   localparam int NUM_BINS      = 1 << (rcws_pkg::MAX_DEPTH_DEF + 1);
   localparam int SETTLE_CYCLES = 12;   // covers the path to the first score and the four-word queue
   localparam int N_DIRECTED    = 23;
   localparam int RANDOM_ITEMS  = 200;
   localparam int CALM_FROM     = 160;  // no random gaps and no new stall bursts from this sample on

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                csr_wr_en;
   logic [rcws_pkg::DEPTH_W-1:0]        csr_wr_data;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [rcws_pkg::REQ_DATA_W-1:0]     req_tdata;     // cut_bits[2:0], response[34:3]
   logic                                req_tuser;     // treated
   logic                                req_tlast;     // last_sample
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [rcws_pkg::RSP_DATA_W-1:0]     rsp_tdata;     // cell_index[2:0], score[51:3]
   logic                                rsp_tlast;     // last_score

   // predictor state: one signed accumulator per bin and the depth last written
   logic signed [rcws_pkg::ACC_WIDTH_DEF-1:0] acc_bins [NUM_BINS];
   logic [rcws_pkg::DEPTH_W-1:0]              cur_depth;
   score_word_type                            score_due [$];
   stim_row_type                              directed_rows [N_DIRECTED];
   int                                        mismatches = 0;
   int                                        stall_left = 0;
   logic                                      calm = 1'b0;

   always #5 clock = ~clock;

   rule_cell_weighted_bin_scorer_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("mismatch in %s: got %0h, want %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // bin update for one accepted sample; on the last sample of a set the scores of
   // every rule cell fall due and the bins start again from zero
   task automatic accumulate_sample(input logic treated,
                                    input logic [rcws_pkg::CUT_W-1:0] cut,
                                    input logic [rcws_pkg::RESP_W-1:0] resp, input logic last,
                                    input logic typed,
                                    input logic [rcws_pkg::SCORE_W-1:0] cell0_score);
      int                                  eff;
      int                                  ncell;
      int                                  b;
      logic [rcws_pkg::CUT_W-1:0]          live_cut;
      logic signed [rcws_pkg::SCORE_W-1:0] t_sum;
      logic signed [rcws_pkg::SCORE_W-1:0] u_sum;
      score_word_type                      w;
      // depth saturates at the largest cut count; cut bits above the depth are dropped
      eff = (cur_depth > rcws_pkg::MAX_DEPTH_DEF) ? rcws_pkg::MAX_DEPTH_DEF : int'(cur_depth);
      ncell = 1 << eff;
      live_cut = cut & rcws_pkg::CUT_W'(ncell - 1);
      b = int'({live_cut, treated});
      acc_bins[b] = acc_bins[b] +
                    {{(rcws_pkg::ACC_WIDTH_DEF - rcws_pkg::RESP_W){resp[rcws_pkg::RESP_W-1]}},
                     resp};
      if (last) begin
         for (int j = 0; j < ncell; j++) begin
            // sign extended bins, difference wraps at the score width
            t_sum = rcws_pkg::SCORE_W'(acc_bins[2*j + 1]);
            u_sum = rcws_pkg::SCORE_W'(acc_bins[2*j]);
            w.cell_idx = rcws_pkg::CELL_IDX_W'(j);
            w.score = t_sum - u_sum;
            w.last = (j == ncell - 1);
            if (typed) begin
               w.score = (j == 0) ? cell0_score : '0;
            end
            score_due = {score_due, w};
         end
         foreach (acc_bins[i]) acc_bins[i] = '0;
      end
   endtask

   // one sample word on the req channel; valid stays high until the handshake
   task automatic put_sample(input logic treated, input logic [rcws_pkg::CUT_W-1:0] cut,
                             input logic [rcws_pkg::RESP_W-1:0] resp, input logic last,
                             input logic typed,
                             input logic [rcws_pkg::SCORE_W-1:0] cell0_score);
      req_tvalid <= 1'b1;
      req_tuser  <= treated;
      req_tlast  <= last;
      req_tdata  <= rcws_pkg::REQ_DATA_W'({resp, cut});
      do @(posedge clock); while (!req_tready);
      accumulate_sample(treated, cut, resp, last, typed, cell0_score);
   endtask

   task automatic pause_sender(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic maybe_gap();
      if (!calm && $urandom_range(0, 5) == 0) begin
         pause_sender($urandom_range(1, 8));
      end
   endtask

   // depth is written only with the block idle: every score in and the queue drained
   task automatic write_depth(input logic [rcws_pkg::DEPTH_W-1:0] v);
      req_tvalid <= 1'b0;
      while (score_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cur_depth = v;
   endtask

   task automatic random_sample(input logic last);
      logic [rcws_pkg::RESP_W-1:0] r;
      case ($urandom_range(0, 9))
         0: r = 32'h7FFF_FFFF;
         1: r = 32'h8000_0000;
         2, 3, 4: r = rcws_pkg::RESP_W'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
         default: r = $urandom;
      endcase
      put_sample(1'($urandom_range(0, 1)), rcws_pkg::CUT_W'($urandom_range(0, 7)), r, last,
                 1'b0, '0);
   endtask

   task automatic check_score(input logic [rcws_pkg::CELL_IDX_W-1:0] idx,
                              input logic [rcws_pkg::SCORE_W-1:0] score, input logic last);
      score_word_type w;
      if (score_due.size() == 0) begin
         flag_mismatch("score word with none due", 64'({idx, score}), '0);
      end else begin
         w = score_due.pop_front();
         if (idx !== w.cell_idx) flag_mismatch("cell_index", 64'(idx), 64'(w.cell_idx));
         if (score !== w.score) flag_mismatch("score", 64'(score), 64'(w.score));
         if (last !== w.last) flag_mismatch("last_score", 64'(last), 64'(w.last));
      end
   endtask

   function automatic stim_row_type mk(input row_kind_type kind,
                                       input logic [rcws_pkg::DEPTH_W-1:0] dep,
                                       input logic t, input logic [rcws_pkg::CUT_W-1:0] c,
                                       input logic [rcws_pkg::RESP_W-1:0] r, input logic l,
                                       input logic typed,
                                       input logic [rcws_pkg::SCORE_W-1:0] e);
      stim_row_type row;
      row.kind = kind;
      row.depth = dep;
      row.treated = t;
      row.cut = c;
      row.resp = r;
      row.last = l;
      row.typed = typed;
      row.cell0_score = e;
      return row;
   endfunction

   // receiver: stalls come in random bursts, no new burst once calm
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // every accepted score word is held against the oldest one due
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_score(rsp_tdata[rcws_pkg::CELL_IDX_W-1:0],
                     rsp_tdata[rcws_pkg::CELL_IDX_W +: rcws_pkg::SCORE_W], rsp_tlast);
      end
   end

   // hard stop well beyond the slowest correct run
   initial begin
      #3000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int sent;
      int phase;
      int set_len;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= 1'b0;
      req_tlast   <= 1'b0;
      rsp_tready  <= 1'b0;
      cur_depth = rcws_pkg::DEPTH_RESET;
      foreach (acc_bins[i]) acc_bins[i] = '0;

      // directed table
      // after reset, depth one: a lone treated sample in cell 0
      directed_rows[0]  = mk(ROW_SAMPLE, '0, 1'b1, 3'd0, 32'h0000_0001, 1'b1, 1'b1, 49'h1);
      // no cut levels: cut bits ignored, one score per set
      directed_rows[1]  = mk(ROW_DEPTH,  2'd0, '0, '0, '0, '0, '0, '0);
      directed_rows[2]  = mk(ROW_SAMPLE, '0, 1'b1, 3'd7, 32'h7FFF_FFFF, 1'b1, 1'b1,
                             49'h0_7FFF_FFFF);
      directed_rows[3]  = mk(ROW_SAMPLE, '0, 1'b0, 3'd5, 32'h8000_0000, 1'b1, 1'b1,
                             49'h0_8000_0000);
      // full depth, extremes spread over several cells
      directed_rows[4]  = mk(ROW_DEPTH,  2'd3, '0, '0, '0, '0, '0, '0);
      directed_rows[5]  = mk(ROW_SAMPLE, '0, 1'b1, 3'd7, 32'h7FFF_FFFF, 1'b0, 1'b0, '0);
      directed_rows[6]  = mk(ROW_SAMPLE, '0, 1'b0, 3'd7, 32'h8000_0000, 1'b0, 1'b0, '0);
      directed_rows[7]  = mk(ROW_SAMPLE, '0, 1'b1, 3'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
      directed_rows[8]  = mk(ROW_SAMPLE, '0, 1'b0, 3'd3, 32'h0001_0000, 1'b0, 1'b0, '0);
      directed_rows[9]  = mk(ROW_SAMPLE, '0, 1'b1, 3'd5, 32'h1234_5678, 1'b1, 1'b0, '0);
      // cut bits above the depth are masked off
      directed_rows[10] = mk(ROW_DEPTH,  2'd2, '0, '0, '0, '0, '0, '0);
      directed_rows[11] = mk(ROW_SAMPLE, '0, 1'b1, 3'd7, 32'h0000_8000, 1'b0, 1'b0, '0);
      directed_rows[12] = mk(ROW_SAMPLE, '0, 1'b0, 3'd4, 32'h7FFF_FFFF, 1'b1, 1'b0, '0);
      // negative sums beyond the response range
      directed_rows[13] = mk(ROW_DEPTH,  2'd1, '0, '0, '0, '0, '0, '0);
      directed_rows[14] = mk(ROW_SAMPLE, '0, 1'b0, 3'd6, 32'h8000_0000, 1'b0, 1'b0, '0);
      directed_rows[15] = mk(ROW_SAMPLE, '0, 1'b0, 3'd6, 32'h8000_0000, 1'b0, 1'b0, '0);
      directed_rows[16] = mk(ROW_SAMPLE, '0, 1'b1, 3'd1, 32'h7FFF_FFFF, 1'b1, 1'b0, '0);
      // depth changed in the middle of a set
      directed_rows[17] = mk(ROW_DEPTH,  2'd3, '0, '0, '0, '0, '0, '0);
      directed_rows[18] = mk(ROW_SAMPLE, '0, 1'b1, 3'd6, 32'h0003_0000, 1'b0, 1'b0, '0);
      directed_rows[19] = mk(ROW_DEPTH,  2'd1, '0, '0, '0, '0, '0, '0);
      directed_rows[20] = mk(ROW_SAMPLE, '0, 1'b0, 3'd3, 32'hFFFF_0000, 1'b1, 1'b0, '0);
      directed_rows[21] = mk(ROW_DEPTH,  2'd3, '0, '0, '0, '0, '0, '0);
      directed_rows[22] = mk(ROW_SAMPLE, '0, 1'b1, 3'd7, 32'h8000_0000, 1'b1, 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_DEPTH) begin
            write_depth(directed_rows[i].depth);
         end else begin
            maybe_gap();
            put_sample(directed_rows[i].treated, directed_rows[i].cut, directed_rows[i].resp,
                       directed_rows[i].last, directed_rows[i].typed,
                       directed_rows[i].cell0_score);
         end
      end

      // random phases: a depth write, then a few complete sets; now and then a set is
      // left open so that its samples run into the next depth
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase == 0) begin
            write_depth(2'd0);
         end else if (phase == 1) begin
            write_depth(2'd3);
         end else begin
            write_depth(rcws_pkg::DEPTH_W'($urandom_range(0, 3)));
         end
         repeat ($urandom_range(1, 4)) begin
            set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            for (int k = 0; k < set_len; k++) begin
               if (sent == CALM_FROM) calm <= 1'b1;
               maybe_gap();
               random_sample(k == set_len - 1);
               sent++;
            end
         end
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
               if (sent == CALM_FROM) calm <= 1'b1;
               maybe_gap();
               random_sample(1'b0);
               sent++;
            end
         end
         phase++;
      end
      // close whatever set is still open
      random_sample(1'b1);
      req_tvalid <= 1'b0;

      while (score_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
